// ----- hdl/kmp_pkg.sv -----
// Shared constants, types and helper function of the keyboard macro player.
package kmp_pkg;

    // Store geometry.
    localparam int FIXED_SLOTS         = 8;
    localparam int FIXED_SLOT_BYTES    = 64;
    localparam int WRITABLE_SLOTS      = 8;
    localparam int WRITABLE_SLOT_BYTES = 32;

    localparam int FIXED_DEPTH    = FIXED_SLOTS * FIXED_SLOT_BYTES;
    localparam int WRITABLE_DEPTH = WRITABLE_SLOTS * WRITABLE_SLOT_BYTES;
    localparam int TOTAL_SLOTS    = FIXED_SLOTS + WRITABLE_SLOTS;
    localparam int BURST_KEYS     = 32;

    localparam int MAX_SLOT_BYTES = (FIXED_SLOT_BYTES > WRITABLE_SLOT_BYTES) ?
                                    FIXED_SLOT_BYTES : WRITABLE_SLOT_BYTES;

    // Derived widths.
    localparam int POS_W      = $clog2(MAX_SLOT_BYTES + 2);
    localparam int FADDR_W    = (FIXED_DEPTH > 1) ? $clog2(FIXED_DEPTH) : 1;
    localparam int WADDR_W    = (WRITABLE_DEPTH > 1) ? $clog2(WRITABLE_DEPTH) : 1;
    localparam int KEY_CNT_W  = $clog2(BURST_KEYS);
    localparam int TPS_W      = 9;
    localparam int TICK_W     = 16;

    // Fixed values.
    localparam logic [TPS_W-1:0] TPS_RESET   = 9'd75;
    localparam logic [6:0]       DELAY_MASK  = 7'h7F;
    localparam logic [7:0]       KEY_END_HI  = 8'd255;
    localparam logic [7:0]       SLOT_RESET  = 8'd255;

    // Action codes of an input item.
    localparam logic [2:0] ACT_LOAD_FIXED    = 3'd0;
    localparam logic [2:0] ACT_LOAD_WRITABLE = 3'd1;
    localparam logic [2:0] ACT_START         = 3'd2;
    localparam logic [2:0] ACT_TICK          = 3'd3;
    localparam logic [2:0] ACT_CLOSE         = 3'd4;
    localparam logic [2:0] ACT_QUERY         = 3'd5;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_MARKER = 2'd1,
        KIND_END    = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    // Input item.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] macro_index;
        logic [8:0] byte_address;
        logic [7:0] byte_value;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_index;
        logic       present;
        logic       last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_fixed;
        logic  load_writable;
        logic  start_play;
        logic  tick_inc;
        logic  resume;
        logic  query_rd;
        logic  issue;
        logic  key_done;
        logic  stop;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic playing;
        logic tick_ready;
        logic slot_out;
        logic pos_end;
        logic key_valid;
        logic delay_nz;
        logic burst_full;
    } status_t;

    // A key byte is a real key unless it is an end marker.
    function automatic logic valid_key(input logic [7:0] k);
        return (k != 8'd0) && (k != KEY_END_HI);
    endfunction

endpackage

// ----- hdl/kmp_dp.sv -----
// Datapath of the macro player: stores, play state registers and the result register.
module kmp_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [8:0]       cfg_data,
    input  kmp_pkg::item_t   item,
    input  kmp_pkg::cmd_t    cmd,
    output kmp_pkg::status_t st,
    output kmp_pkg::result_t result,
    output logic             result_strobe
);

    // Play state.
    logic [kmp_pkg::TPS_W-1:0]     tps_reg;
    logic                          playing_reg;
    logic [7:0]                    slot_reg;
    logic [kmp_pkg::POS_W-1:0]     pos_reg;
    logic [kmp_pkg::TICK_W-1:0]    target_reg;
    logic [kmp_pkg::TICK_W-1:0]    tick_reg;
    logic [kmp_pkg::KEY_CNT_W-1:0] keys_reg;
    logic                          dly_oob_reg;
    logic                          q_fixed_reg;
    logic                          q_wr_reg;
    logic                          strobe_reg;
    kmp_pkg::result_t              result_reg;

    // Registered store read data.
    logic [7:0] fkey_reg;
    logic [7:0] fdly_reg;
    logic [7:0] wkey_reg;

    // Stores.
    logic [7:0] fixed_mem [kmp_pkg::FIXED_DEPTH];
    logic [7:0] wr_mem    [kmp_pkg::WRITABLE_DEPTH];

    logic                          slot_fixed;
    logic [kmp_pkg::TICK_W-1:0]    tick_inc_val;
    logic [7:0]                    rd_slot;
    logic [kmp_pkg::POS_W-1:0]     rd_pos;
    logic [7:0]                    wslot;
    logic [kmp_pkg::FADDR_W:0]     fa;
    logic [kmp_pkg::FADDR_W:0]     fda;
    logic [kmp_pkg::WADDR_W:0]     wa;
    logic                          dly_oob;
    logic                          rd_en;
    logic                          fixed_we;
    logic                          wr_we;
    logic [7:0]                    play_key;
    logic [6:0]                    play_dly;
    logic [7:0]                    q_key;
    logic [kmp_pkg::POS_W-1:0]     pos_step;
    logic [kmp_pkg::POS_W-1:0]     slot_size;
    logic [kmp_pkg::TICK_W-1:0]    delay_prod;

    // Slot kind, tick increment with saturation, delay product, position step and slot size.
    assign slot_fixed   = slot_reg < 8'(kmp_pkg::FIXED_SLOTS);
    assign tick_inc_val = (&tick_reg) ? tick_reg : tick_reg + 16'd1;
    assign delay_prod   = 16'(play_dly) * 16'(tps_reg);
    assign pos_step     = slot_fixed ? kmp_pkg::POS_W'(2) : kmp_pkg::POS_W'(1);
    assign slot_size    = slot_fixed ? kmp_pkg::POS_W'(kmp_pkg::FIXED_SLOT_BYTES)
                                     : kmp_pkg::POS_W'(kmp_pkg::WRITABLE_SLOT_BYTES);

    // Read addresses: a query reads the first byte of the requested slot.
    assign rd_slot = cmd.query_rd ? item.macro_index : slot_reg;
    assign rd_pos  = cmd.query_rd ? '0 : pos_reg;
    assign wslot   = rd_slot - 8'(kmp_pkg::FIXED_SLOTS);
    assign fa      = (kmp_pkg::FADDR_W+1)'(rd_slot) *
                     (kmp_pkg::FADDR_W+1)'(kmp_pkg::FIXED_SLOT_BYTES) +
                     (kmp_pkg::FADDR_W+1)'(rd_pos);
    assign fda     = fa + (kmp_pkg::FADDR_W+1)'(1);
    assign dly_oob = fda >= (kmp_pkg::FADDR_W+1)'(kmp_pkg::FIXED_DEPTH);
    assign wa      = (kmp_pkg::WADDR_W+1)'(wslot) *
                     (kmp_pkg::WADDR_W+1)'(kmp_pkg::WRITABLE_SLOT_BYTES) +
                     (kmp_pkg::WADDR_W+1)'(rd_pos);
    assign rd_en   = cmd.query_rd || cmd.issue;

    // Loads beyond a store are dropped.
    assign fixed_we = cmd.load_fixed && (32'(item.byte_address) < kmp_pkg::FIXED_DEPTH);
    assign wr_we    = cmd.load_writable &&
                      (32'(item.byte_address) < kmp_pkg::WRITABLE_DEPTH);

    // Fixed store: one write port, key and delay read ports.
    always_ff @(posedge clk)
    begin
        if (fixed_we)
        begin
            fixed_mem[kmp_pkg::FADDR_W'(item.byte_address)] <= item.byte_value;
        end
        if (rd_en)
        begin
            fkey_reg <= fixed_mem[fa[kmp_pkg::FADDR_W-1:0]];
            fdly_reg <= fixed_mem[fda[kmp_pkg::FADDR_W-1:0]];
        end
    end

    // Writable store: one write port, one read port.
    always_ff @(posedge clk)
    begin
        if (wr_we)
        begin
            wr_mem[kmp_pkg::WADDR_W'(item.byte_address)] <= item.byte_value;
        end
        if (rd_en)
        begin
            wkey_reg <= wr_mem[wa[kmp_pkg::WADDR_W-1:0]];
        end
    end

    // Decode of the entry just read.
    assign play_key = slot_fixed ? fkey_reg : wkey_reg;
    assign play_dly = (slot_fixed && !dly_oob_reg) ? (fdly_reg[6:0] & kmp_pkg::DELAY_MASK)
                                                   : 7'd0;
    assign q_key    = q_fixed_reg ? fkey_reg : (q_wr_reg ? wkey_reg : 8'd0);

    // Status to the controller.
    always_comb
    begin
        st.playing    = playing_reg;
        st.tick_ready = tick_inc_val >= target_reg;
        st.slot_out   = slot_reg >= 8'(kmp_pkg::TOTAL_SLOTS);
        st.pos_end    = pos_reg >= slot_size;
        st.key_valid  = kmp_pkg::valid_key(play_key);
        st.delay_nz   = play_dly != 7'd0;
        st.burst_full = keys_reg == kmp_pkg::KEY_CNT_W'(kmp_pkg::BURST_KEYS - 1);
    end

    // Control and play state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg     <= kmp_pkg::TPS_RESET;
            playing_reg <= 1'b0;
            slot_reg    <= kmp_pkg::SLOT_RESET;
            pos_reg     <= '0;
            target_reg  <= '0;
            tick_reg    <= '0;
            keys_reg    <= '0;
            dly_oob_reg <= 1'b0;
            q_fixed_reg <= 1'b0;
            q_wr_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_data;
            end
            priority if (cmd.start_play)
            begin
                playing_reg <= 1'b1;
                slot_reg    <= item.macro_index;
                pos_reg     <= '0;
                tick_reg    <= '0;
                target_reg  <= '0;
                keys_reg    <= '0;
            end
            else if (cmd.resume)
            begin
                tick_reg   <= '0;
                target_reg <= '0;
                keys_reg   <= '0;
            end
            else if (cmd.tick_inc)
            begin
                tick_reg <= tick_inc_val;
            end
            else
            begin
                tick_reg <= tick_reg;
            end
            if (cmd.issue)
            begin
                pos_reg     <= pos_reg + pos_step;
                dly_oob_reg <= dly_oob;
            end
            if (cmd.key_done)
            begin
                keys_reg <= keys_reg + kmp_pkg::KEY_CNT_W'(1);
                if (st.delay_nz)
                begin
                    target_reg <= delay_prod;
                end
            end
            if (cmd.stop)
            begin
                playing_reg <= 1'b0;
            end
            if (cmd.query_rd)
            begin
                q_fixed_reg <= item.macro_index < 8'(kmp_pkg::FIXED_SLOTS);
                q_wr_reg    <= (item.macro_index >= 8'(kmp_pkg::FIXED_SLOTS)) &&
                               (item.macro_index < 8'(kmp_pkg::TOTAL_SLOTS));
            end
            strobe_reg <= cmd.emit;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.kind      <= cmd.emit_kind;
            result_reg.key_index <= (cmd.emit_kind == kmp_pkg::KIND_KEY) ? play_key : 8'd0;
            result_reg.present   <= (cmd.emit_kind == kmp_pkg::KIND_QUERY) ?
                                    kmp_pkg::valid_key(q_key) : 1'b0;
            result_reg.last      <= cmd.emit_last;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // An end result always leaves the player idle.
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (cmd.emit_kind == kmp_pkg::KIND_END) |=> !playing_reg)
        else $error("end result left the player running");

    // Only key results may be followed by more results of the same item.
    a_nonkey_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && (result_reg.kind != kmp_pkg::KIND_KEY) |-> result_reg.last)
        else $error("non-key result without last mark");

endmodule

// ----- hdl/kmp_ctrl.sv -----
// Controller state machine of the macro player: decodes actions and sequences playback.
module kmp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       action,
    input  kmp_pkg::status_t st,
    output kmp_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUERY,
        S_ISSUE,
        S_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        cmd.emit_kind = kmp_pkg::KIND_KEY;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        kmp_pkg::ACT_LOAD_FIXED:
                        begin
                            cmd.load_fixed = 1'b1;
                        end
                        kmp_pkg::ACT_LOAD_WRITABLE:
                        begin
                            cmd.load_writable = 1'b1;
                        end
                        kmp_pkg::ACT_START:
                        begin
                            if (!st.playing)
                            begin
                                cmd.start_play = 1'b1;
                                state_next     = S_ISSUE;
                            end
                        end
                        kmp_pkg::ACT_TICK:
                        begin
                            if (st.playing)
                            begin
                                cmd.tick_inc = 1'b1;
                                if (st.tick_ready)
                                begin
                                    cmd.resume = 1'b1;
                                    state_next = S_ISSUE;
                                end
                            end
                        end
                        kmp_pkg::ACT_CLOSE:
                        begin
                            if (st.playing)
                            begin
                                cmd.stop      = 1'b1;
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = kmp_pkg::KIND_END;
                                cmd.emit_last = 1'b1;
                            end
                        end
                        kmp_pkg::ACT_QUERY:
                        begin
                            cmd.query_rd = 1'b1;
                            state_next   = S_QUERY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_QUERY:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = kmp_pkg::KIND_QUERY;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_ISSUE:
            begin
                // A slot beyond both stores or the end of the slot finishes playback.
                if (st.slot_out || st.pos_end)
                begin
                    cmd.stop      = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = kmp_pkg::KIND_END;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!st.key_valid)
                begin
                    cmd.stop      = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = kmp_pkg::KIND_MARKER;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    // A delay or a full burst pauses until a later tick.
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = kmp_pkg::KIND_KEY;
                    cmd.emit_last = st.delay_nz || st.burst_full;
                    cmd.key_done  = 1'b1;
                    state_next    = (st.delay_nz || st.burst_full) ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An entry is evaluated only right after it was read.
    a_eval_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ($past(state_reg) == S_ISSUE))
        else $error("evaluate without a preceding read");

    // A read is only issued inside a live slot.
    a_issue_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (st.playing && !st.pos_end && !st.slot_out))
        else $error("read issued outside the slot");

    // Apart from a query, the controller is busy only while a macro plays.
    a_busy_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (st.playing || (state_reg == S_QUERY)))
        else $error("busy without a playing macro");

endmodule

// ----- hdl/keyboard_macro_player.sv -----
// Top level of the keyboard macro player: controller and datapath.
//
//  Channel   Handshake            Payload              Transfer at
//  input     start / busy         item   (item_t)      start high, busy low
//  result    result_strobe        result (result_t)    every strobe cycle
//  config    cfg_we               cfg_data [8:0]       cfg_we high
//
// Loads write a store. A close result shows in the cycle after the close is taken.
// A query result passes through the registered store read and the S_QUERY state.
// Playback starts, then reads and evaluates each key in turn (S_ISSUE, S_EVAL) and
// ends at the slot size; one item plays up to 32 keys.
// Reset (rst_n low, asynchronous) clears play state; the stores hold no reset.
// The receiver cannot stall: each result stands on the ports for one cycle.
module keyboard_macro_player (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [8:0]       cfg_data,
    input  logic             start,
    output logic             busy,
    input  kmp_pkg::item_t   item,
    output kmp_pkg::result_t result,
    output logic             result_strobe
);

    kmp_pkg::cmd_t    cmd;
    kmp_pkg::status_t st;

    // Sequencing.
    kmp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Stores and play state.
    kmp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .item          (item),
        .cmd           (cmd),
        .st            (st),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

// ----- tb/tb_keyboard_macro_player.sv -----
// Self-checking testbench of the keyboard macro player, with its own playback predictor.
module tb_keyboard_macro_player;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes that the block does not use.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam logic [7:0] KEY_END_LO  = 8'h00;

    // How a directed row is checked.
    localparam int ROW_PREDICT = 0;
    localparam int ROW_SILENT  = 1;
    localparam int ROW_TYPED   = 2;

    // The two slots that are filled, played and queried: the last of each store.
    localparam int PLAY_FIXED_SLOT = kmp_pkg::FIXED_SLOTS - 1;
    localparam int PLAY_USER_SLOT  = kmp_pkg::TOTAL_SLOTS - 1;
    localparam int FIX_BASE        = PLAY_FIXED_SLOT * kmp_pkg::FIXED_SLOT_BYTES;
    localparam int USER_BASE       = (PLAY_USER_SLOT - kmp_pkg::FIXED_SLOTS) *
                                     kmp_pkg::WRITABLE_SLOT_BYTES;

    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 25;
    localparam int TICK_BUDGET    = 12;
    localparam int MAX_PRINTS     = 40;

    typedef struct {
        kmp_pkg::item_t   stim;
        int               form;
        kmp_pkg::result_t want;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [8:0]       cfg_data = '0;
    logic             start = 1'b0;
    logic             busy;
    kmp_pkg::item_t   item = '0;
    kmp_pkg::result_t result;
    logic             result_strobe;

    keyboard_macro_player dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe)
    );

    always #5 clk = ~clk;

    // Predicted playback state and both byte stores.
    logic [7:0]  fixed_bytes [kmp_pkg::FIXED_DEPTH];
    logic [7:0]  user_bytes [kmp_pkg::WRITABLE_DEPTH];
    bit          macro_active = 1'b0;
    int unsigned cur_slot = 255;
    int unsigned read_ofs = 0;
    int unsigned wait_goal = 0;
    int unsigned tick_total = 0;
    int unsigned steps_per_delay = 75;

    kmp_pkg::result_t item_reports[$];
    kmp_pkg::result_t pending_reports[$];
    dir_row_t         directed_rows[$];

    // Handshake bookkeeping shared by the driver and the monitor.
    bit               took_item = 1'b0;
    int               row_form = ROW_PREDICT;
    kmp_pkg::result_t row_want = '0;
    int               idle_pct = 0;
    int               sent_in_phase = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    int unsigned phase_tps [PHASES] = '{1, 0, 500, 511, 2};
    int          phase_idle [PHASES] = '{0, 70, 33, 0, 70};

    function automatic bit is_key(logic [7:0] k);
        return (k != KEY_END_LO) && (k != kmp_pkg::KEY_END_HI);
    endfunction

    function automatic void add_report(kmp_pkg::kind_t k, logic [7:0] key, logic pres);
        kmp_pkg::result_t r;
        r.kind      = k;
        r.key_index = key;
        r.present   = pres;
        r.last      = 1'b0;
        item_reports.push_back(r);
    endfunction

    // Emit keys until a delay, an end marker, the slot size, the burst limit or a slot beyond both stores.
    function automatic void run_burst();
        int unsigned keys;
        int unsigned base;
        int unsigned slot_bytes;
        logic [7:0]  key_b;
        logic [7:0]  dly_b;
        keys       = 0;
        tick_total = 0;
        wait_goal  = 0;
        while (1) begin
            if (cur_slot >= kmp_pkg::TOTAL_SLOTS) begin
                macro_active = 1'b0;
                add_report(kmp_pkg::KIND_END, 8'd0, 1'b0);
                return;
            end
            if (keys >= kmp_pkg::BURST_KEYS)
                return;
            slot_bytes = (cur_slot < kmp_pkg::FIXED_SLOTS) ? kmp_pkg::FIXED_SLOT_BYTES
                                                           : kmp_pkg::WRITABLE_SLOT_BYTES;
            if (read_ofs >= slot_bytes) begin
                macro_active = 1'b0;
                add_report(kmp_pkg::KIND_END, 8'd0, 1'b0);
                return;
            end
            if (cur_slot < kmp_pkg::FIXED_SLOTS) begin
                base  = cur_slot * kmp_pkg::FIXED_SLOT_BYTES + read_ofs;
                key_b = fixed_bytes[base];
                dly_b = (base + 1 < kmp_pkg::FIXED_DEPTH) ? fixed_bytes[base + 1] : 8'd0;
                read_ofs += 2;
            end else begin
                base  = (cur_slot - kmp_pkg::FIXED_SLOTS) * kmp_pkg::WRITABLE_SLOT_BYTES +
                        read_ofs;
                key_b = user_bytes[base];
                dly_b = 8'd0;
                read_ofs += 1;
            end
            if (!is_key(key_b)) begin
                macro_active = 1'b0;
                add_report(kmp_pkg::KIND_MARKER, 8'd0, 1'b0);
                return;
            end
            add_report(kmp_pkg::KIND_KEY, key_b, 1'b0);
            keys++;
            if (dly_b[6:0] != 7'd0) begin
                wait_goal = (int'(dly_b[6:0]) * steps_per_delay) & 32'hFFFF;
                return;
            end
        end
    endfunction

    // Work out the reports that one accepted item causes.
    function automatic void predict_reports(kmp_pkg::item_t it);
        int unsigned      slot;
        logic [7:0]       first;
        kmp_pkg::result_t tail;
        item_reports.delete();
        slot = it.macro_index;
        case (it.action)
            kmp_pkg::ACT_LOAD_FIXED: fixed_bytes[it.byte_address] = it.byte_value;
            kmp_pkg::ACT_LOAD_WRITABLE:
                if (it.byte_address < kmp_pkg::WRITABLE_DEPTH)
                    user_bytes[it.byte_address] = it.byte_value;
            kmp_pkg::ACT_START:
                if (!macro_active) begin
                    macro_active = 1'b1;
                    cur_slot     = slot;
                    read_ofs     = 0;
                    run_burst();
                end
            kmp_pkg::ACT_TICK:
                if (macro_active) begin
                    if (tick_total < 32'hFFFF)
                        tick_total++;
                    if (tick_total >= wait_goal)
                        run_burst();
                end
            kmp_pkg::ACT_CLOSE:
                if (macro_active) begin
                    macro_active = 1'b0;
                    add_report(kmp_pkg::KIND_END, 8'd0, 1'b0);
                end
            kmp_pkg::ACT_QUERY: begin
                first = 8'd0;
                if (slot < kmp_pkg::FIXED_SLOTS)
                    first = fixed_bytes[slot * kmp_pkg::FIXED_SLOT_BYTES];
                else if (slot < kmp_pkg::TOTAL_SLOTS)
                    first = user_bytes[(slot - kmp_pkg::FIXED_SLOTS) *
                                       kmp_pkg::WRITABLE_SLOT_BYTES];
                add_report(kmp_pkg::KIND_QUERY, 8'd0, is_key(first));
            end
            default: ;
        endcase
        if (item_reports.size() != 0) begin
            tail      = item_reports.pop_back();
            tail.last = 1'b1;
            item_reports.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Monitor: record accepted items, check each report, and watch for a hang.
    always @(posedge clk) begin : monitor
        kmp_pkg::result_t want;
        took_item = rst_n && start && !busy;
        if (took_item) begin
            predict_reports(item);
            if (row_form == ROW_PREDICT)
                foreach (item_reports[i]) pending_reports.push_back(item_reports[i]);
            else if (row_form == ROW_TYPED)
                pending_reports.push_back(row_want);
        end
        if (rst_n && result_strobe) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINTS)
                    $display("%0t: unexpected report, expected none, got %h", $time, result);
            end else begin
                want = pending_reports.pop_front();
                check_field("kind", 8'(want.kind), 8'(result.kind));
                check_field("key_index", want.key_index, result.key_index);
                check_field("present", 8'(want.present), 8'(result.present));
                check_field("last", 8'(want.last), 8'(result.last));
            end
        end
        if (took_item || (rst_n && result_strobe))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[keyboard_macro_player] ERROR");
            $finish;
        end
    end

    // Drive one item from a falling edge and return at the falling edge after its transfer.
    task automatic send_item(kmp_pkg::item_t it, int form, kmp_pkg::result_t want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        item     <= it;
        row_form  = form;
        row_want  = want;
        sent_in_phase++;
        do @(negedge clk); while (!took_item);
    endtask

    task automatic send(logic [2:0] act, logic [7:0] idx, logic [8:0] addr, logic [7:0] val);
        kmp_pkg::item_t it;
        it.action       = act;
        it.macro_index  = idx;
        it.byte_address = addr;
        it.byte_value   = val;
        send_item(it, ROW_PREDICT, '0);
    endtask

    task automatic add_row(int form, logic [2:0] act, logic [7:0] idx, logic [8:0] addr,
                           logic [7:0] val, kmp_pkg::kind_t k, logic [7:0] key, logic pres);
        dir_row_t row;
        row.stim.action       = act;
        row.stim.macro_index  = idx;
        row.stim.byte_address = addr;
        row.stim.byte_value   = val;
        row.form              = form;
        row.want.kind         = k;
        row.want.key_index    = key;
        row.want.present      = pres;
        row.want.last         = 1'b1;
        directed_rows.push_back(row);
    endtask

    // Mostly no wait; long waits are rare when a delay step is many ticks.
    function automatic logic [7:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < ((steps_per_delay > 50) ? 93 : 65))
            return {1'($urandom_range(1)), 7'd0};
        else if (r < 97)
            return {1'($urandom_range(1)), 7'($urandom_range(1, 2))};
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] end_marker();
        return ($urandom_range(1) == 1) ? kmp_pkg::KEY_END_HI : KEY_END_LO;
    endfunction

    // A slot that is filled, or one beyond both stores.
    function automatic logic [7:0] pick_slot();
        int unsigned r;
        r = $urandom_range(2);
        if (r == 0)
            return 8'(PLAY_FIXED_SLOT);
        else if (r == 1)
            return 8'(PLAY_USER_SLOT);
        return 8'($urandom_range(kmp_pkg::TOTAL_SLOTS, 255));
    endfunction

    // Write a short macro, or a full slot with no end marker, into one slot.
    task automatic program_slot(int unsigned slot);
        int unsigned len;
        int unsigned base;
        bit          full;
        full = ($urandom_range(99) < 15);
        if (slot < kmp_pkg::FIXED_SLOTS) begin
            base = slot * kmp_pkg::FIXED_SLOT_BYTES;
            len  = full ? kmp_pkg::FIXED_SLOT_BYTES / 2 : $urandom_range(1, 6);
            for (int unsigned i = 0; i < len; i++) begin
                send(kmp_pkg::ACT_LOAD_FIXED, 8'($urandom), 9'(base + 2 * i),
                     8'($urandom_range(1, 254)));
                send(kmp_pkg::ACT_LOAD_FIXED, 8'($urandom), 9'(base + 2 * i + 1),
                     full ? 8'd0 : pick_delay());
            end
            if (!full && $urandom_range(1) == 1)
                send(kmp_pkg::ACT_LOAD_FIXED, 8'($urandom), 9'(base + 2 * len),
                     end_marker());
        end else begin
            base = (slot - kmp_pkg::FIXED_SLOTS) * kmp_pkg::WRITABLE_SLOT_BYTES;
            len  = full ? kmp_pkg::WRITABLE_SLOT_BYTES : $urandom_range(1, 6);
            for (int unsigned i = 0; i < len; i++)
                send(kmp_pkg::ACT_LOAD_WRITABLE, 8'($urandom), 9'(base + i),
                     8'($urandom_range(1, 254)));
            if (!full && $urandom_range(1) == 1)
                send(kmp_pkg::ACT_LOAD_WRITABLE, 8'($urandom), 9'(base + len), end_marker());
        end
    endtask

    // Start a slot and tick it through, with stray queries, starts and closes.
    task automatic drive_playback(int unsigned slot);
        int unsigned waited;
        int unsigned cap;
        int unsigned r;
        send(kmp_pkg::ACT_START, 8'(slot), 9'($urandom), 8'($urandom));
        cap    = TICK_BUDGET;
        waited = 0;
        while (macro_active && waited < cap) begin
            r = $urandom_range(99);
            if (r < 4)
                send(kmp_pkg::ACT_QUERY, pick_slot(), 9'($urandom), 8'($urandom));
            else if (r < 7)
                send(kmp_pkg::ACT_START, pick_slot(), 9'($urandom), 8'($urandom));
            else if (r < 9)
                send(kmp_pkg::ACT_CLOSE, 8'($urandom), 9'($urandom), 8'($urandom));
            else
                send(kmp_pkg::ACT_TICK, 8'($urandom), 9'($urandom), 8'($urandom));
            waited++;
        end
        if (macro_active)
            send(kmp_pkg::ACT_CLOSE, 8'($urandom), 9'($urandom), 8'($urandom));
    endtask

    // Let every expected report arrive, then let the block fall idle.
    task automatic settle();
        start <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tps(logic [8:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        steps_per_delay = v;
    endtask

    initial begin
        int unsigned r;
        int unsigned slot;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the two slots that are played and queried, so no read meets an unwritten entry.
        idle_pct = 0;
        for (int unsigned a = 0; a < kmp_pkg::FIXED_SLOT_BYTES; a++)
            send(kmp_pkg::ACT_LOAD_FIXED, 8'($urandom), 9'(FIX_BASE + a),
                 (a % 2 == 0) ? 8'($urandom) : pick_delay());
        for (int unsigned a = 0; a < kmp_pkg::WRITABLE_SLOT_BYTES; a++)
            send(kmp_pkg::ACT_LOAD_WRITABLE, 8'($urandom), 9'(USER_BASE + a), 8'($urandom));

        // Directed rows: ignored actions, out-of-range slots, end markers, masked delays.
        add_row(ROW_SILENT, ACT_SPARE_6, 8'hFF, 9'h1FF, 8'hFF, kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, ACT_SPARE_7, 8'h00, 9'h000, 8'h00, kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_TICK, 8'h00, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_CLOSE, 8'hFF, 9'h1FF, 8'hFF,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_QUERY, 8'hFF, 9'h000, 8'h00,
                kmp_pkg::KIND_QUERY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_QUERY, 8'd16, 9'h000, 8'h00,
                kmp_pkg::KIND_QUERY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_START, 8'hFF, 9'h000, 8'h00,
                kmp_pkg::KIND_END, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_START, 8'd16, 9'h000, 8'h00,
                kmp_pkg::KIND_END, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_WRITABLE, 8'h00, 9'h1FF, 8'hFF,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_FIXED, 8'h00, 9'(FIX_BASE), KEY_END_LO,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_QUERY, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_QUERY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_START, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_MARKER, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_FIXED, 8'h00, 9'(FIX_BASE), kmp_pkg::KEY_END_HI,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_START, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_MARKER, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_FIXED, 8'h00, 9'(FIX_BASE), 8'd254,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_FIXED, 8'h00, 9'(FIX_BASE + 1), 8'hFF,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_QUERY, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_QUERY, 8'd0, 1'b1);
        add_row(ROW_TYPED, kmp_pkg::ACT_START, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd254, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_START, 8'd3, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_TICK, 8'd0, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_CLOSE, 8'd0, 9'h000, 8'h00,
                kmp_pkg::KIND_END, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_FIXED, 8'h00, 9'(FIX_BASE + 1), 8'h80,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_PREDICT, kmp_pkg::ACT_START, 8'(PLAY_FIXED_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_PREDICT, kmp_pkg::ACT_CLOSE, 8'd0, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_SILENT, kmp_pkg::ACT_LOAD_WRITABLE, 8'h00, 9'(USER_BASE), 8'd1,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_TYPED, kmp_pkg::ACT_QUERY, 8'(PLAY_USER_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_QUERY, 8'd0, 1'b1);
        add_row(ROW_PREDICT, kmp_pkg::ACT_START, 8'(PLAY_USER_SLOT), 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_PREDICT, kmp_pkg::ACT_TICK, 8'd0, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        add_row(ROW_PREDICT, kmp_pkg::ACT_CLOSE, 8'd0, 9'h000, 8'h00,
                kmp_pkg::KIND_KEY, 8'd0, 1'b0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].form, directed_rows[i].want);
        settle();

        // Random phases, each with its own step length and idle rate.
        for (int p = 0; p < PHASES; p++) begin
            write_tps(9'(phase_tps[p]));
            idle_pct      = phase_idle[p];
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    if (macro_active)
                        send(kmp_pkg::ACT_CLOSE, 8'($urandom), 9'($urandom), 8'($urandom));
                    slot = ($urandom_range(1) == 1) ? PLAY_USER_SLOT : PLAY_FIXED_SLOT;
                    program_slot(slot);
                    if ($urandom_range(3) == 0)
                        send(kmp_pkg::ACT_QUERY, 8'(slot), 9'($urandom), 8'($urandom));
                    drive_playback(slot);
                end else if (r < 80) begin
                    drive_playback(pick_slot());
                end else begin
                    repeat ($urandom_range(1, 4))
                        send(3'($urandom), pick_slot(), 9'($urandom), 8'($urandom));
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("[keyboard_macro_player] OK");
        else
            $display("[keyboard_macro_player] ERROR");
        $finish;
    end

endmodule
